// ----- sv/fpba_pkg.sv -----
// Shared types and constants for the fit-policy block allocator.
// No dependencies; every other file in sv/ imports this package.
`timescale 1ns / 1ps

package fpba_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_BLOCKS_DEF = 8;
  localparam int SIZE_BITS_DEF  = 16;

  // Fixed field widths of the channels and the configuration port
  localparam int AMOUNT_W    = 16;
  localparam int SLOT_W      = 3;
  localparam int POLICY_W    = 2;
  localparam int BIU_W       = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_FIT_POLICY    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_BLOCKS_IN_USE = 1'b1;

  // Register reset values
  localparam logic [BIU_W-1:0] BIU_RESET = 4'd8;

  typedef enum logic [POLICY_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_policy_t;

  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_REQUEST = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                func;
    logic [SLOT_W-1:0]   block_slot;
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic                granted;
    logic [SLOT_W-1:0]   chosen_slot;
    logic [AMOUNT_W-1:0] left_over;
  } out_item_t;

  // Status from the shared compare/subtract unit
  typedef struct packed {
    logic fits;    // candidate size covers the request
    logic better;  // candidate beats the current pick under the policy
    logic take;    // candidate becomes the new pick
  } fit_cmp_t;

endpackage

// ----- sv/fpba_fit_unit.sv -----
// Shared compare/subtract unit of the fit-policy block allocator.
// Depends on fpba_pkg for the policy codes and the status struct.
`timescale 1ns / 1ps

module fpba_fit_unit #(
  parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF,
  parameter int AMT_W     = fpba_pkg::AMOUNT_W
) (
  input  logic [fpba_pkg::POLICY_W-1:0] policy,
  input  logic [SIZE_BITS-1:0]          cand,
  input  logic [SIZE_BITS-1:0]          pick,
  input  logic                          have_pick,
  input  logic [AMT_W-1:0]              amount,
  output fpba_pkg::fit_cmp_t            status,
  output logic [SIZE_BITS-1:0]          diff
);
  import fpba_pkg::*;

  logic [AMT_W-1:0] cand_ext;

  assign cand_ext = AMT_W'(cand);
  // Only meaningful when the candidate fits, so the amount fits SIZE_BITS
  assign diff     = cand - amount[SIZE_BITS-1:0];

  always_comb begin
    status.fits = (cand_ext >= amount);
    case (fit_policy_t'(policy))
      FIT_BEST:  status.better = (cand < pick);
      FIT_WORST: status.better = (cand > pick);
      default:   status.better = 1'b0;
    endcase
    status.take = status.fits && (!have_pick || status.better);
  end

endmodule

// ----- sv/fit_policy_block_allocator.sv -----
// Top level of the fit-policy block allocator: free-size table, scan sequencer,
// output register. Depends on fpba_pkg and fpba_fit_unit.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall / in_data) carries one beat per item:
//   a load writes a table entry's free size, a request asks for an amount.
//   Output channel (out_valid / out_stall / out_data) returns one beat per
//   item: grant flag, chosen slot, and the entry's remaining size.
//   Configuration: cfg_write with cfg_index selects fit_policy (first, best,
//   worst fit) or blocks_in_use; write only while the block is idle.
// Sequencing
//   A load goes from accept straight to the final step, which loads its result
//   into the output register once that register is free. A request scans the
//   entries in use one per cycle through the table's registered read port and
//   the shared compare unit, then writes back in the final step. One item is in
//   flight at a time; in_stall is high from the accept until the result is
//   loaded into the output register, so a new item is not taken before that.
// Reset
//   rst clears every entry's valid bit (unwritten entries read as zero),
//   sets fit_policy to first fit and blocks_in_use to eight, and empties the
//   output register. No clearing pass is needed.
// Back-pressure
//   While out_stall holds the output beat, the block may accept and work on
//   the next item; it then waits in its final step until the beat is taken.

module fit_policy_block_allocator #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [fpba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  fpba_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output fpba_pkg::out_item_t              out_data
);
  import fpba_pkg::*;

  localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int LIM_W  = (CNT_W > BIU_W) ? CNT_W : BIU_W;
  localparam int AMT_W  = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;
  localparam int SWID_W = IDX_W + SLOT_W;
  localparam logic [AMT_W-1:0]  SIZE_MAX = AMT_W'({SIZE_BITS{1'b1}});
  localparam logic [LIM_W-1:0]  NB_LIM   = LIM_W'(NUM_BLOCKS);
  localparam logic [SWID_W-1:0] NB_SLOT  = SWID_W'(NUM_BLOCKS);

  // Configuration registers
  logic [POLICY_W-1:0] fit_policy;
  logic [BIU_W-1:0]    blocks_in_use;

  // Sequencer
  state_t state, state_next;
  logic   accept;
  logic   out_free;
  logic   iss_go;
  logic   scan_done;
  logic   finish_fire;

  // Latched item
  logic              op_func;
  logic [SLOT_W-1:0] op_slot;
  logic [AMT_W-1:0]  op_amount;
  logic [LIM_W-1:0]  lim;
  logic [LIM_W-1:0]  lim_in;
  logic [LIM_W-1:0]  biu_ext;

  // Scan pipeline
  logic [LIM_W-1:0]     iss;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_idx;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 rd_entry_vld;
  logic [SIZE_BITS-1:0] cand;
  logic                 found;
  logic [IDX_W-1:0]     pick_idx;
  logic [SIZE_BITS-1:0] pick_size;

  // Table: sizes in a memory, valid bits in flops
  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
  logic                 vbits [NUM_BLOCKS];
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;

  // Shared unit
  fit_cmp_t             cmp;
  logic [SIZE_BITS-1:0] unit_a;
  logic [SIZE_BITS-1:0] diff;

  // Result assembly
  logic [SWID_W-1:0]    slot_wide;
  logic                 slot_ok;
  logic [IDX_W-1:0]     slot_addr;
  logic [AMT_W-1:0]     load_val;
  logic [SIZE_BITS-1:0] load_size;
  logic [SWID_W-1:0]    pick_wide;
  logic [AMT_W-1:0]     load_ext;
  logic [AMT_W-1:0]     diff_ext;
  out_item_t            result;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy    <= FIT_FIRST;
      blocks_in_use <= BIU_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IDX_FIT_POLICY:    fit_policy    <= cfg_data[POLICY_W-1:0];
        CFG_IDX_BLOCKS_IN_USE: blocks_in_use <= cfg_data[BIU_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- sequencer
  assign in_stall    = (state != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign iss_go      = (state == ST_SCAN) && (iss < lim);
  assign scan_done   = (state == ST_SCAN) && !iss_go && !rd_vld;
  assign finish_fire = (state == ST_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (in_data.func == FUNC_REQUEST) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold here until the output register can take the beat
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Clamp the scan length to the table depth
  assign biu_ext = LIM_W'(blocks_in_use);
  assign lim_in  = (biu_ext > NB_LIM) ? NB_LIM : biu_ext;

  // Latch the item on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func   <= in_data.func;
      op_slot   <= in_data.block_slot;
      op_amount <= AMT_W'(in_data.amount);
      lim       <= lim_in;
    end
  end

  // ------------------------------------------------------------ scan loop
  // Issue one table read per cycle; the registered read port returns the entry for comparing.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else begin
      rd_vld <= iss_go;
      if (accept) begin
        found <= 1'b0;
      end else if (rd_vld && cmp.take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      iss <= '0;
    end else if (iss_go) begin
      iss    <= iss + 1'b1;
      rd_idx <= iss[IDX_W-1:0];
    end
    if (rd_vld && cmp.take) begin
      pick_idx  <= rd_idx;
      pick_size <= cand;
    end
  end

  // Registered read port of the table
  always_ff @(posedge clk) begin
    if (iss_go) begin
      rd_data      <= mem[iss[IDX_W-1:0]];
      rd_entry_vld <= vbits[iss[IDX_W-1:0]];
    end
  end

  // Never-written entries read as zero
  assign cand = rd_entry_vld ? rd_data : '0;

  // During the scan the unit rates candidates; at the end it subtracts
  assign unit_a = (state == ST_FINISH) ? pick_size : cand;

  fpba_fit_unit #(
    .SIZE_BITS (SIZE_BITS),
    .AMT_W     (AMT_W)
  ) u_fit (
    .policy    (fit_policy),
    .cand      (unit_a),
    .pick      (pick_size),
    .have_pick (found),
    .amount    (op_amount),
    .status    (cmp),
    .diff      (diff)
  );

  // ----------------------------------------------------------- write-back
  assign slot_wide = SWID_W'(op_slot);
  assign slot_ok   = (slot_wide < NB_SLOT);
  assign slot_addr = slot_wide[IDX_W-1:0];
  // Saturate a load to the largest storable size
  assign load_val  = (op_amount > SIZE_MAX) ? SIZE_MAX : op_amount;
  assign load_size = load_val[SIZE_BITS-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pick_idx;
    wr_data = diff;
    if (finish_fire) begin
      if (op_func == FUNC_LOAD) begin
        wr_en   = slot_ok;
        wr_addr = slot_addr;
        wr_data = load_size;
      end else begin
        wr_en = found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        vbits[i] <= 1'b0;
      end
    end else if (wr_en) begin
      vbits[wr_addr] <= 1'b1;
    end
  end

  // --------------------------------------------------------------- result
  assign pick_wide = SWID_W'(pick_idx);
  assign load_ext  = AMT_W'(load_size);
  assign diff_ext  = AMT_W'(diff);

  always_comb begin
    result = '0;
    if (op_func == FUNC_LOAD) begin
      // a load past the table echoes the slot but writes nothing
      result.chosen_slot = op_slot;
      if (slot_ok) begin
        result.granted   = 1'b1;
        result.left_over = load_ext[AMOUNT_W-1:0];
      end
    end else if (found) begin
      result.granted     = 1'b1;
      result.chosen_slot = pick_wide[SLOT_W-1:0];
      result.left_over   = diff_ext[AMOUNT_W-1:0];
    end
  end

  // Output register: advance on take, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      out_data <= result;
    end
  end

endmodule

// ----- sv/fpba_checker.sv -----
// Port-level checks for the fit-policy block allocator, bound to the top level.
// Depends on fpba_pkg and fit_policy_block_allocator.
`timescale 1ns / 1ps

module fpba_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input fpba_pkg::out_item_t              out_data
);
  import fpba_pkg::*;

  logic in_beat;

  assign in_beat = in_valid && !in_stall;

  // Reset leaves the block ready with an empty output register
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // One item at a time: an accepted beat makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> in_stall)
    else $error("input accepted while an item is in flight");

  // No result appears in the cycle after its item is accepted
  a_no_zero_latency: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !$rose(out_valid))
    else $error("result appeared without latency");

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (.*);

// ----- dv/fit_policy_block_allocator_tb.sv -----
// Self-checking testbench for fit_policy_block_allocator: directed table, then random phases.
// Depends on fpba_pkg and the allocator RTL in sv/; needs nothing else to run.
`timescale 1ns / 1ps

module fit_policy_block_allocator_tb;
  import fpba_pkg::*;

  localparam int NUM_BLOCKS      = NUM_BLOCKS_DEF;
  localparam int RAND_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int TAIL_CYCLES     = 24;
  localparam int REPORT_MAX      = 10;

  // Policy code with no enum member; the block must treat it as first fit
  localparam logic [POLICY_W-1:0] FIT_UNUSED = 2'd3;

  typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_INDEX_W-1:0]   cfg_idx;
    int                       cfg_val;
    in_item_t                 beat;
    bit                       typed;
    out_item_t                typed_res;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;

  // Shadow of the allocator: free-size table and both registers
  logic [AMOUNT_W-1:0]    free_tbl [NUM_BLOCKS];
  logic [POLICY_W-1:0]    policy_q;
  logic [BIU_W-1:0]       biu_q;

  out_item_t              expected_grants [$];
  stim_row_t              stim_rows [$];

  bit                     quiet = 1'b0;
  int                     stall_left = 0;
  int                     cycle_cnt = 0;
  int                     fail_cnt = 0;
  int                     items_sent = 0;
  int                     results_seen = 0;
  int                     grants_seen = 0;
  out_item_t              head_grant;

  fit_policy_block_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // Predict the result of one accepted beat and advance the shadow table.
  // A load always lands (the slot field cannot exceed the table and the amount
  // cannot exceed the entry width); a request scans the entries in use.
  function automatic out_item_t alloc_predict(input in_item_t beat);
    out_item_t res;
    int        limit;
    bit        found;
    int        pick;
    res   = '0;
    found = 1'b0;
    pick  = 0;
    if (beat.func == FUNC_LOAD) begin
      free_tbl[beat.block_slot] = beat.amount;
      res.granted     = 1'b1;
      res.chosen_slot = beat.block_slot;
      res.left_over   = beat.amount;
    end else begin
      // Clamp blocks_in_use to the table; zero leaves nothing to scan
      limit = (int'(biu_q) > NUM_BLOCKS) ? NUM_BLOCKS : int'(biu_q);
      for (int j = 0; j < limit; j++) begin
        if (free_tbl[j] >= beat.amount) begin
          if (!found) begin
            found = 1'b1;
            pick  = j;
            if (policy_q != FIT_BEST && policy_q != FIT_WORST) break;
          end else if (policy_q == FIT_BEST && free_tbl[j] < free_tbl[pick]) begin
            pick = j;
          end else if (policy_q == FIT_WORST && free_tbl[j] > free_tbl[pick]) begin
            pick = j;
          end
        end
      end
      if (found) begin
        free_tbl[pick]  = free_tbl[pick] - beat.amount;
        res.granted     = 1'b1;
        res.chosen_slot = pick[SLOT_W-1:0];
        res.left_over   = free_tbl[pick];
      end
    end
    return res;
  endfunction

  // Build a random beat. Most requests are sized off a live table entry so
  // they land, hit an exact fit, or just miss; the rest are extremes and noise.
  function automatic in_item_t make_random_item();
    in_item_t beat;
    int       j;
    beat            = '0;
    beat.block_slot = SLOT_W'($urandom_range(0, NUM_BLOCKS - 1));
    j               = $urandom_range(0, NUM_BLOCKS - 1);
    if ($urandom_range(0, 99) < 35) begin
      beat.func = FUNC_LOAD;
      case ($urandom_range(0, 9))
        0:          beat.amount = '0;
        1:          beat.amount = '1;
        2, 3, 4, 5: beat.amount = AMOUNT_W'($urandom_range(0, 1023));
        default:    beat.amount = AMOUNT_W'($urandom);
      endcase
    end else begin
      beat.func = FUNC_REQUEST;
      case ($urandom_range(0, 19))
        0:       beat.amount = '0;
        1:       beat.amount = '1;
        2, 3:    beat.amount = AMOUNT_W'($urandom);
        4, 5:    beat.amount = free_tbl[j];
        6:       beat.amount = free_tbl[j] + 1'b1;
        default: beat.amount = AMOUNT_W'($urandom_range(0, free_tbl[j]));
      endcase
    end
    return beat;
  endfunction

  task automatic note_failure(input string what, input out_item_t want, input out_item_t got);
    fail_cnt++;
    if (fail_cnt <= REPORT_MAX) begin
      $display("[%0t] %s: want granted=%0d slot=%0d left=%0d, got granted=%0d slot=%0d left=%0d",
               $time, what, want.granted, want.chosen_slot, want.left_over,
               got.granted, got.chosen_slot, got.left_over);
    end
  endtask

  task automatic add_cfg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    stim_row_t row;
    row           = '{kind: ROW_CFG, default: '0};
    row.kind      = ROW_CFG;
    row.cfg_idx   = idx;
    row.cfg_val   = val;
    stim_rows.push_back(row);
  endtask

  // Queue one directed beat; when typed is set the result is given here
  // instead of coming from the predictor.
  task automatic add_item(input func_t f, input int slot, input int amt,
                          input bit typed, input bit g, input int s, input int l);
    stim_row_t row;
    row                       = '{kind: ROW_ITEM, default: '0};
    row.kind                  = ROW_ITEM;
    row.beat.func             = f;
    row.beat.block_slot       = slot[SLOT_W-1:0];
    row.beat.amount           = amt[AMOUNT_W-1:0];
    row.typed                 = typed;
    row.typed_res.granted     = g;
    row.typed_res.chosen_slot = s[SLOT_W-1:0];
    row.typed_res.left_over   = l[AMOUNT_W-1:0];
    stim_rows.push_back(row);
  endtask

  // Drive one input beat at the falling edge, optionally after an idle burst,
  // hold it until a rising edge sees the block not stalling, then predict.
  task automatic send_beat(input in_item_t beat, input bit typed, input out_item_t typed_res);
    out_item_t predicted;
    int        gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = alloc_predict(beat);
    expected_grants.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // Write one register with the block idle: drop valid, drain every pending
  // result, wait, then pulse the write enable.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_IDX_FIT_POLICY) policy_q = val[POLICY_W-1:0];
    else biu_q = val[BIU_W-1:0];
  endtask

  // Output back-pressure: random stall bursts of random length, none started when quiet
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Check every accepted output beat against the oldest pending result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.granted === 1'b1) grants_seen++;
      if (expected_grants.size() == 0) begin
        note_failure("result with nothing pending", '0, out_data);
      end else begin
        head_grant = expected_grants.pop_front();
        if (out_data.granted !== head_grant.granted ||
            out_data.chosen_slot !== head_grant.chosen_slot ||
            out_data.left_over !== head_grant.left_over) begin
          note_failure("result mismatch", head_grant, out_data);
        end
      end
    end
  end

  // Watchdog: end the run if the block hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_grants.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int biu_pick;
    int directed_cnt;

    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    for (int j = 0; j < NUM_BLOCKS; j++) free_tbl[j] = '0;
    policy_q  = FIT_FIRST;
    biu_q     = BIU_RESET;

    // Directed table. Typed rows carry results that follow straight from the
    // reset table, a single candidate, or a refusal; the rest use the predictor.
    add_item(FUNC_REQUEST, 0, 0,       1, 1, 0, 0);       // zero request fits an empty entry
    add_item(FUNC_REQUEST, 5, 'hFFFF,  1, 0, 0, 0);       // refused on the reset table
    add_item(FUNC_LOAD,    7, 'hFFFF,  1, 1, 7, 'hFFFF);
    add_item(FUNC_LOAD,    0, 100,     1, 1, 0, 100);
    add_item(FUNC_LOAD,    2, 'hAAAA,  1, 1, 2, 'hAAAA);
    add_item(FUNC_LOAD,    4, 'h5555,  1, 1, 4, 'h5555);
    add_item(FUNC_LOAD,    3, 50,      1, 1, 3, 50);
    add_item(FUNC_LOAD,    5, 300,     1, 1, 5, 300);
    add_item(FUNC_REQUEST, 2, 'hFFFF,  1, 1, 7, 0);       // only the full entry fits
    add_item(FUNC_REQUEST, 0, 40,      0, 0, 0, 0);
    add_cfg(CFG_IDX_FIT_POLICY, FIT_BEST);
    add_item(FUNC_REQUEST, 0, 40,      0, 0, 0, 0);
    add_item(FUNC_REQUEST, 0, 60,      0, 0, 0, 0);       // exact fit
    add_cfg(CFG_IDX_FIT_POLICY, FIT_WORST);
    add_item(FUNC_LOAD,    1, 'hAAAA,  1, 1, 1, 'hAAAA);
    add_item(FUNC_REQUEST, 6, 5,       0, 0, 0, 0);       // tie on the largest entry
    add_cfg(CFG_IDX_FIT_POLICY, FIT_UNUSED);
    add_item(FUNC_REQUEST, 0, 5,       0, 0, 0, 0);
    add_cfg(CFG_IDX_BLOCKS_IN_USE, 0);
    add_item(FUNC_REQUEST, 0, 0,       1, 0, 0, 0);       // nothing in use
    add_item(FUNC_LOAD,    6, 1,       1, 1, 6, 1);       // load beyond the entries in use
    add_cfg(CFG_IDX_FIT_POLICY, FIT_BEST);
    add_cfg(CFG_IDX_BLOCKS_IN_USE, 15);                   // clamps to the table size
    add_item(FUNC_REQUEST, 0, 1,       0, 0, 0, 0);
    add_cfg(CFG_IDX_BLOCKS_IN_USE, 1);
    add_item(FUNC_REQUEST, 0, 1,       1, 0, 0, 0);
    add_item(FUNC_LOAD,    0, 'h8000,  1, 1, 0, 'h8000);
    add_item(FUNC_REQUEST, 3, 'h8000,  0, 0, 0, 0);
    add_cfg(CFG_IDX_BLOCKS_IN_USE, BIU_RESET);
    add_cfg(CFG_IDX_FIT_POLICY, FIT_WORST);
    add_item(FUNC_REQUEST, 0, 0,       0, 0, 0, 0);

    // Hold reset, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        write_reg(stim_rows[i].cfg_idx, stim_rows[i].cfg_val);
      end else begin
        send_beat(stim_rows[i].beat, stim_rows[i].typed, stim_rows[i].typed_res);
      end
    end
    directed_cnt = items_sent;

    // Random phases: policy steps through every code, blocks_in_use starts on
    // its extremes and then mostly stays inside the table. Last two run quiet.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      quiet = (phase >= RAND_PHASES - 2);
      case (phase)
        0:       biu_pick = BIU_RESET;
        1:       biu_pick = 1;
        2:       biu_pick = 15;
        3:       biu_pick = 0;
        default: begin
          case ($urandom_range(0, 9))
            0:       biu_pick = 0;
            1:       biu_pick = $urandom_range(9, 15);
            2, 3:    biu_pick = NUM_BLOCKS;
            default: biu_pick = $urandom_range(1, NUM_BLOCKS);
          endcase
        end
      endcase
      write_reg(CFG_IDX_FIT_POLICY, phase % 4);
      write_reg(CFG_IDX_BLOCKS_IN_USE, biu_pick);
      repeat (ITEMS_PER_PHASE) send_beat(make_random_item(), 1'b0, '0);
    end

    // Drain, then give the block a tail to show any stray result
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    fail_cnt += expected_grants.size();

    $display("covered %0d beats (%0d directed, %0d random) over %0d register settings",
             items_sent, directed_cnt, items_sent - directed_cnt, RAND_PHASES + 1);
    $display("checked %0d results, %0d granted, %0d failures",
             results_seen, grants_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
